// File: hw/rtl/pcsw_pkg.sv
`timescale 1ns / 1ps

package pcsw_pkg;

    localparam int MAX_POINTS = 131072;
    localparam int XY_SLICES  = 1600;
    localparam int Z_SLICES   = 350;
    localparam int NHEADS     = 2 * XY_SLICES + Z_SLICES;

    localparam int PTR_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = PTR_W + 1;
    localparam int HEAD_AW = $clog2(NHEADS);
    localparam int HEAD_W  = PTR_W + 1;
    localparam int LINK_W  = PTR_W + 1;
    localparam int COORD_W = 24;
    localparam int REFL_W  = 32;
    localparam int CFG_W   = 13;
    localparam int SL_W    = 11;
    localparam int SLN_W   = 13;
    localparam int CEN_W   = 22;
    localparam int PRD_W   = CNT_W + 1 + CEN_W;
    localparam int SUM_W   = COORD_W + CNT_W;
    localparam int MOV_W   = COORD_W + 2;

    // floor(c / 1000) via biased reciprocal multiply, exact for 25-bit operands
    localparam int                 Q_W    = 16;
    localparam int                 U_W    = COORD_W + 1;
    localparam int                 DIV_SH = 36;
    localparam int                 BIAS_Q = 8389;
    localparam logic [U_W-1:0]     BIAS   = U_W'(BIAS_Q * 1000);
    localparam logic [26:0]        RECIP  = 27'd68719477;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MARK  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        AX_X    = 2'd0,
        AX_Y    = 2'd1,
        AX_Z    = 2'd2,
        AX_NONE = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        REG_BIG_SHIFT    = 2'd0,
        REG_SMALL_SHIFT  = 2'd1,
        REG_NEAR_BAND    = 2'd2,
        REG_CENTRE_NUDGE = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_HEAD,
        ST_LD_LINK,
        ST_MK_HEAD,
        ST_MK_FIRST,
        ST_S1_RD,
        ST_S1_ACC,
        ST_CMP_MUL,
        ST_CMP,
        ST_S2_RD,
        ST_S2_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] big_shift;
        logic [CFG_W-1:0] small_shift;
        logic [CFG_W-1:0] near_band;
        logic [CFG_W-1:0] centre_nudge;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic ld_mul;
        logic ld_head;
        logic ld_link;
        logic mk_head;
        logic mk_first;
        logic s1_acc;
        logic cmp_mul;
        logic cmp;
        logic s2_wr;
        logic rd_addr;
        logic rd_data;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic mark_bad;
        logic rd_bad;
        logic clr_last;
        logic last_axis;
        logic head_valid;
        logic s1_last;
        logic act;
        logic s2_last;
    } sts_t;

    function automatic logic [SLN_W-1:0] axis_slices(input logic [1:0] a);
        return (a == AX_Z) ? SLN_W'(Z_SLICES) : SLN_W'(XY_SLICES);
    endfunction

    function automatic logic [SLN_W-1:0] axis_half(input logic [1:0] a);
        return (a == AX_Z) ? SLN_W'(Z_SLICES / 2) : SLN_W'(XY_SLICES / 2);
    endfunction

    function automatic logic [HEAD_AW-1:0] axis_base(input logic [1:0] a);
        logic [HEAD_AW-1:0] b;
        unique case (a)
            AX_X:    b = '0;
            AX_Y:    b = HEAD_AW'(XY_SLICES);
            default: b = HEAD_AW'(2 * XY_SLICES);
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/pcsw_ctrl.sv
`timescale 1ns / 1ps

module pcsw_ctrl
    import pcsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  logic       out_ready,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       in_ready,
    output logic       out_valid
);

    state_t state_reg, state_next;
    logic   clr_res_reg, clr_res_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_res_next = clr_res_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (sts.clr_last)
                    state_next = clr_res_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_LOAD:  state_next = sts.full ? ST_DONE : ST_LD_MUL;
                        OP_MARK:  state_next = sts.mark_bad ? ST_DONE : ST_MK_HEAD;
                        OP_READ:  state_next = sts.rd_bad ? ST_DONE : ST_RD_ADDR;
                        default:
                        begin
                            state_next   = ST_CLR;
                            clr_res_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LD_MUL:   state_next = ST_LD_HEAD;
            ST_LD_HEAD:  state_next = ST_LD_LINK;
            ST_LD_LINK:  state_next = sts.last_axis ? ST_DONE : ST_LD_MUL;
            ST_MK_HEAD:  state_next = ST_MK_FIRST;
            ST_MK_FIRST: state_next = sts.head_valid ? ST_S1_RD : ST_DONE;
            ST_S1_RD:    state_next = ST_S1_ACC;
            ST_S1_ACC:   state_next = sts.s1_last ? ST_CMP_MUL : ST_S1_RD;
            ST_CMP_MUL:  state_next = ST_CMP;
            ST_CMP:      state_next = sts.act ? ST_S2_RD : ST_DONE;
            ST_S2_RD:    state_next = ST_S2_WR;
            ST_S2_WR:    state_next = sts.s2_last ? ST_DONE : ST_S2_RD;
            ST_RD_ADDR:  state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next   = ST_IDLE;
                    clr_res_next = 1'b0;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.clr_step = (state_reg == ST_CLR);
        cmd.ld_mul   = (state_reg == ST_LD_MUL);
        cmd.ld_head  = (state_reg == ST_LD_HEAD);
        cmd.ld_link  = (state_reg == ST_LD_LINK);
        cmd.mk_head  = (state_reg == ST_MK_HEAD);
        cmd.mk_first = (state_reg == ST_MK_FIRST);
        cmd.s1_acc   = (state_reg == ST_S1_ACC);
        cmd.cmp_mul  = (state_reg == ST_CMP_MUL);
        cmd.cmp      = (state_reg == ST_CMP);
        cmd.s2_wr    = (state_reg == ST_S2_WR);
        cmd.rd_addr  = (state_reg == ST_RD_ADDR);
        cmd.rd_data  = (state_reg == ST_RD_DATA);
        cmd.out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        in_ready     = (state_reg == ST_IDLE);
        out_valid    = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

// File: hw/rtl/pcsw_dp.sv
`timescale 1ns / 1ps

module pcsw_dp
    import pcsw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  cfg_t                      cfg,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [REFL_W-1:0]         reflect_raw,
    input  logic [1:0]                axis,
    input  logic [SL_W-1:0]           slice,
    input  logic                      mark_bit,
    input  logic [PTR_W-1:0]          point_index,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic [REFL_W-1:0]         out_reflect,
    output logic [CNT_W-1:0]          points_in_slice,
    output logic [CNT_W-1:0]          points_moved,
    output logic                      bit_used,
    output logic [1:0]                status
);

    // point store, slice links and heads
    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_z [MAX_POINTS];
    logic [REFL_W-1:0]         mem_r [MAX_POINTS];
    logic [LINK_W-1:0]         lnk_x [MAX_POINTS];
    logic [LINK_W-1:0]         lnk_y [MAX_POINTS];
    logic [LINK_W-1:0]         lnk_z [MAX_POINTS];
    logic [HEAD_W-1:0]         heads [NHEADS];

    // control state
    logic [CNT_W-1:0]   cnt_reg;
    logic [HEAD_AW-1:0] clr_idx_reg;

    // latched item
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [REFL_W-1:0]         refl_reg;
    logic [1:0]                ax_reg;
    logic [SL_W-1:0]           sl_reg;
    logic                      bit_reg;
    logic [PTR_W-1:0]          idx_reg;

    // work registers
    logic [Q_W-1:0]              q_reg;
    logic [HEAD_AW-1:0]          h_reg;
    logic                        inr_reg;
    logic [PTR_W-1:0]            ptr_reg, hp_reg;
    logic [CNT_W-1:0]            n_reg, k_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [CEN_W-1:0]     centre_reg;
    logic signed [PRD_W-1:0]     prod_reg;
    logic signed [MOV_W-1:0]     t_reg, tb_reg;

    // read data
    logic signed [COORD_W-1:0] rdx_reg, rdy_reg, rdz_reg;
    logic [REFL_W-1:0]         rdr_reg;
    logic [LINK_W-1:0]         rlx_reg, rly_reg, rlz_reg;
    logic [HEAD_W-1:0]         hd_reg;

    // pending result and output registers
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic [REFL_W-1:0]         res_r_reg;
    logic [CNT_W-1:0]          res_cnt_reg, res_mov_reg;
    logic                      res_used_reg;
    status_t                   res_sts_reg;
    logic signed [COORD_W-1:0] o_x_reg, o_y_reg, o_z_reg;
    logic [REFL_W-1:0]         o_r_reg;
    logic [CNT_W-1:0]          o_cnt_reg, o_mov_reg;
    logic                      o_used_reg;
    status_t                   o_sts_reg;

    // combinational
    logic                      full, mark_bad, rd_bad;
    status_t                   st_init;
    logic signed [COORD_W-1:0] c_sel;
    logic [U_W-1:0]            u_val;
    logic [Q_W+DIV_SH-1:0]     dprod;
    logic signed [Q_W:0]       s_val;
    logic                      inr;
    logic [HEAD_AW-1:0]        h_ld, h_mk;
    logic [HEAD_AW-1:0]        h_rd;
    logic [PTR_W-1:0]          st_addr;
    logic signed [COORD_W-1:0] c_rd;
    logic [LINK_W-1:0]         l_rd;
    logic signed [SLN_W:0]     sl_s;
    logic signed [CEN_W-1:0]   centre_c;
    logic signed [MOV_W-1:0]   t_c, tb_c, c_ext, sh_ext, nc_ext;
    logic signed [COORD_W-1:0] nc;
    logic                      mv, big;
    logic                      wr_ld, wr_mv;

    assign full     = (cnt_reg == CNT_W'(MAX_POINTS));
    assign mark_bad = (axis == AX_NONE) || (SLN_W'(slice) >= axis_slices(axis));
    assign rd_bad   = (CNT_W'(point_index) >= cnt_reg);

    always_comb
    begin
        st_init = STS_OK;
        unique case (opcode)
            OP_LOAD:  if (full) st_init = STS_FULL;
            OP_MARK:  if (mark_bad) st_init = STS_RANGE;
            OP_READ:  if (rd_bad) st_init = STS_INDEX;
            default:  st_init = STS_OK;
        endcase
    end

    // slice of the current load axis
    always_comb
    begin
        unique case (ax_reg)
            AX_X:    c_sel = cx_reg;
            AX_Y:    c_sel = cy_reg;
            default: c_sel = cz_reg;
        endcase
        u_val = U_W'(c_sel) + BIAS;
        dprod = (Q_W+DIV_SH)'(u_val) * (Q_W+DIV_SH)'(RECIP);
        s_val = $signed({1'b0, q_reg})
                - $signed((Q_W+1)'(BIAS_Q) - (Q_W+1)'(axis_half(ax_reg)));
        inr   = (s_val >= 0) && (s_val < $signed((Q_W+1)'(axis_slices(ax_reg))));
        h_ld  = axis_base(ax_reg) + s_val[HEAD_AW-1:0];
        h_mk  = axis_base(ax_reg) + HEAD_AW'(sl_reg);
        h_rd  = cmd.mk_head ? h_mk : h_ld;
    end

    // mark arithmetic
    always_comb
    begin
        unique case (ax_reg)
            AX_X:
            begin
                c_rd = rdx_reg;
                l_rd = rlx_reg;
            end
            AX_Y:
            begin
                c_rd = rdy_reg;
                l_rd = rly_reg;
            end
            default:
            begin
                c_rd = rdz_reg;
                l_rd = rlz_reg;
            end
        endcase
        sl_s     = $signed({2'b00, sl_reg}) - $signed({1'b0, axis_half(ax_reg)});
        centre_c = CEN_W'(sl_s) * 22'sd1000 + 22'sd500;
        t_c      = bit_reg ? MOV_W'(centre_reg) + $signed(MOV_W'(cfg.centre_nudge))
                           : MOV_W'(centre_reg) - $signed(MOV_W'(cfg.centre_nudge));
        tb_c     = bit_reg ? t_c - $signed(MOV_W'(cfg.near_band))
                           : t_c + $signed(MOV_W'(cfg.near_band));
        c_ext    = MOV_W'(c_rd);
        mv       = bit_reg ? (c_ext < t_reg) : (c_ext >= t_reg);
        big      = bit_reg ? (c_ext < tb_reg) : (c_ext > tb_reg);
        sh_ext   = $signed(MOV_W'(big ? cfg.big_shift : cfg.small_shift));
        nc_ext   = bit_reg ? c_ext + sh_ext : c_ext - sh_ext;
        if (nc_ext > MOV_W'(C_MAX))
            nc = C_MAX;
        else if (nc_ext < MOV_W'(C_MIN))
            nc = C_MIN;
        else
            nc = nc_ext[COORD_W-1:0];
    end

    assign wr_ld   = cmd.ld_link && (ax_reg == AX_Z);
    assign wr_mv   = cmd.s2_wr && mv;
    assign st_addr = cmd.rd_addr ? idx_reg : ptr_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_ld)
            mem_x[cnt_reg[PTR_W-1:0]] <= cx_reg;
        else if (wr_mv && ax_reg == AX_X)
            mem_x[ptr_reg] <= nc;
        rdx_reg <= mem_x[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_ld)
            mem_y[cnt_reg[PTR_W-1:0]] <= cy_reg;
        else if (wr_mv && ax_reg == AX_Y)
            mem_y[ptr_reg] <= nc;
        rdy_reg <= mem_y[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_ld)
            mem_z[cnt_reg[PTR_W-1:0]] <= cz_reg;
        else if (wr_mv && ax_reg == AX_Z)
            mem_z[ptr_reg] <= nc;
        rdz_reg <= mem_z[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_ld)
            mem_r[cnt_reg[PTR_W-1:0]] <= refl_reg;
        rdr_reg <= mem_r[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_link && inr_reg && ax_reg == AX_X)
            lnk_x[cnt_reg[PTR_W-1:0]] <= {~hd_reg[HEAD_W-1], hd_reg[PTR_W-1:0]};
        rlx_reg <= lnk_x[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_link && inr_reg && ax_reg == AX_Y)
            lnk_y[cnt_reg[PTR_W-1:0]] <= {~hd_reg[HEAD_W-1], hd_reg[PTR_W-1:0]};
        rly_reg <= lnk_y[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_link && inr_reg && ax_reg == AX_Z)
            lnk_z[cnt_reg[PTR_W-1:0]] <= {~hd_reg[HEAD_W-1], hd_reg[PTR_W-1:0]};
        rlz_reg <= lnk_z[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            heads[clr_idx_reg] <= '0;
        else if (cmd.ld_link && inr_reg)
            heads[h_reg] <= {1'b1, cnt_reg[PTR_W-1:0]};
        hd_reg <= heads[h_rd];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.capture && opcode == OP_CLEAR)
            begin
                cnt_reg     <= '0;
                clr_idx_reg <= '0;
            end
            else
            begin
                if (cmd.clr_step)
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                if (wr_ld)
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // work and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cx_reg       <= coord_x;
            cy_reg       <= coord_y;
            cz_reg       <= coord_z;
            refl_reg     <= reflect_raw;
            ax_reg       <= (opcode == OP_MARK) ? axis : AX_X;
            sl_reg       <= slice;
            bit_reg      <= mark_bit;
            idx_reg      <= point_index;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            res_z_reg    <= '0;
            res_r_reg    <= '0;
            res_cnt_reg  <= '0;
            res_mov_reg  <= '0;
            res_used_reg <= 1'b0;
            res_sts_reg  <= st_init;
        end
        if (cmd.ld_mul)
            q_reg <= dprod[Q_W+DIV_SH-1:DIV_SH];
        if (cmd.ld_head)
        begin
            h_reg   <= h_ld;
            inr_reg <= inr;
        end
        if (cmd.ld_link)
        begin
            if (!inr_reg)
                res_sts_reg <= STS_RANGE;
            if (ax_reg != AX_Z)
                ax_reg <= ax_reg + 1'b1;
        end
        if (cmd.mk_head)
        begin
            centre_reg <= centre_c;
            sum_reg    <= '0;
            n_reg      <= '0;
        end
        if (cmd.mk_first)
        begin
            ptr_reg <= hd_reg[PTR_W-1:0];
            hp_reg  <= hd_reg[PTR_W-1:0];
        end
        if (cmd.s1_acc)
        begin
            sum_reg     <= sum_reg + SUM_W'(c_rd);
            n_reg       <= n_reg + 1'b1;
            res_cnt_reg <= n_reg + 1'b1;
            ptr_reg     <= l_rd[PTR_W-1:0];
        end
        if (cmd.cmp_mul)
            prod_reg <= $signed({1'b0, n_reg}) * centre_reg;
        if (cmd.cmp)
        begin
            res_used_reg <= 1'b1;
            t_reg        <= t_c;
            tb_reg       <= tb_c;
            ptr_reg      <= hp_reg;
            k_reg        <= '0;
        end
        if (cmd.s2_wr)
        begin
            if (mv)
                res_mov_reg <= res_mov_reg + 1'b1;
            k_reg   <= k_reg + 1'b1;
            ptr_reg <= l_rd[PTR_W-1:0];
        end
        if (cmd.rd_data)
        begin
            res_x_reg <= rdx_reg;
            res_y_reg <= rdy_reg;
            res_z_reg <= rdz_reg;
            res_r_reg <= rdr_reg;
        end
        if (cmd.out_load)
        begin
            o_x_reg    <= res_x_reg;
            o_y_reg    <= res_y_reg;
            o_z_reg    <= res_z_reg;
            o_r_reg    <= res_r_reg;
            o_cnt_reg  <= res_cnt_reg;
            o_mov_reg  <= res_mov_reg;
            o_used_reg <= res_used_reg;
            o_sts_reg  <= res_sts_reg;
        end
    end

    always_comb
    begin
        sts.full       = full;
        sts.mark_bad   = mark_bad;
        sts.rd_bad     = rd_bad;
        sts.clr_last   = (clr_idx_reg == HEAD_AW'(NHEADS - 1));
        sts.last_axis  = (ax_reg == AX_Z);
        sts.head_valid = hd_reg[HEAD_W-1];
        sts.s1_last    = l_rd[LINK_W-1] || (n_reg == CNT_W'(MAX_POINTS - 1));
        sts.act        = bit_reg ? (sum_reg < SUM_W'(prod_reg))
                                 : (sum_reg >= SUM_W'(prod_reg));
        sts.s2_last    = l_rd[LINK_W-1] || ((k_reg + 1'b1) == n_reg);
    end

    assign out_x           = o_x_reg;
    assign out_y           = o_y_reg;
    assign out_z           = o_z_reg;
    assign out_reflect     = o_r_reg;
    assign points_in_slice = o_cnt_reg;
    assign points_moved    = o_mov_reg;
    assign bit_used        = o_used_reg;
    assign status          = o_sts_reg;

endmodule

// File: hw/rtl/point_cloud_slice_watermark.sv
`timescale 1ns / 1ps

// Stores lidar points and links each into an x, y and z slice list (1000-unit
// slices), embeds one watermark bit per mark item by walking a slice list, and
// reads points back. One item is worked at a time; every item gives one result,
// held in an output register so the next item can be accepted while it waits.
// A load finds the point's slice on each axis in turn and links it; a mark reads the
// slice head, walks the slice list once to sum its points, compares, and
// walks it again to move points when the bit calls for it. Memory reads are
// registered. After reset and after a clear item, a pass clears all 3550
// slice heads before the next item.
module point_cloud_slice_watermark
    import pcsw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [REFL_W-1:0]         reflect_raw,
    input  logic [1:0]                axis,
    input  logic [SL_W-1:0]           slice,
    input  logic                      mark_bit,
    input  logic [PTR_W-1:0]          point_index,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic [REFL_W-1:0]         out_reflect,
    output logic [CNT_W-1:0]          points_in_slice,
    output logic [CNT_W-1:0]          points_moved,
    output logic                      bit_used,
    output logic [1:0]                status
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    sts_t     sts;
    cfg_idx_t reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.big_shift    <= CFG_W'(500);
            cfg_reg.small_shift  <= CFG_W'(200);
            cfg_reg.near_band    <= CFG_W'(100);
            cfg_reg.centre_nudge <= CFG_W'(50);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_BIG_SHIFT:    cfg_reg.big_shift    <= pwdata[CFG_W-1:0];
                REG_SMALL_SHIFT:  cfg_reg.small_shift  <= pwdata[CFG_W-1:0];
                REG_NEAR_BAND:    cfg_reg.near_band    <= pwdata[CFG_W-1:0];
                REG_CENTRE_NUDGE: cfg_reg.centre_nudge <= pwdata[CFG_W-1:0];
                default:          cfg_reg.big_shift    <= cfg_reg.big_shift;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BIG_SHIFT:    prdata = 32'(cfg_reg.big_shift);
            REG_SMALL_SHIFT:  prdata = 32'(cfg_reg.small_shift);
            REG_NEAR_BAND:    prdata = 32'(cfg_reg.near_band);
            REG_CENTRE_NUDGE: prdata = 32'(cfg_reg.centre_nudge);
            default:          prdata = '0;
        endcase
    end

    pcsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    pcsw_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg_reg),
        .opcode          (opcode),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .reflect_raw     (reflect_raw),
        .axis            (axis),
        .slice           (slice),
        .mark_bit        (mark_bit),
        .point_index     (point_index),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .out_reflect     (out_reflect),
        .points_in_slice (points_in_slice),
        .points_moved    (points_moved),
        .bit_used        (bit_used),
        .status          (status)
    );

endmodule
